/* rtl/c3zs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 sharpening convolution.
// No dependencies; every other file of the block but c3zs_ram uses it.
package c3zs_pkg;

  localparam int KERNEL_SIZE        = 3;
  localparam int CHANNELS           = 3;
  localparam int PIXEL_W            = 8;
  localparam int COEF_W             = 16;
  localparam int COEF_FRACTION_BITS = 8;
  localparam int PROD_W             = COEF_W + PIXEL_W + 1;
  localparam int SUM_W              = PROD_W + 4;
  localparam int HEIGHT_LIMIT       = 1024;
  localparam int DIM_W              = 11;
  localparam int COEF_ROW_W         = COEF_W * KERNEL_SIZE;
  localparam int CFG_DATA_W         = COEF_ROW_W;
  localparam int CFG_INDEX_W        = 3;
  localparam int WORD_W             = PIXEL_W * CHANNELS;

  localparam logic [PIXEL_W-1:0]    PIXEL_MAX      = 8'hFF;
  localparam logic [1:0]            GREY_CHANNELS  = 2'd1;
  localparam logic [1:0]            CH_RESET       = 2'd3;
  localparam logic [DIM_W-1:0]      WIDTH_RESET    = 11'd640;
  localparam logic [DIM_W-1:0]      HEIGHT_RESET   = 11'd480;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = 48'h0000_0100_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHANNEL_COUNT,
    CFG_SHARPEN_MODE,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_COEF_TOP,
    CFG_COEF_MIDDLE,
    CFG_COEF_BOTTOM
  } cfg_index_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_blue;
    logic [PIXEL_W-1:0] pixel_green;
    logic [PIXEL_W-1:0] pixel_red;
    logic               flush;
  } pix_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_blue;
    logic [PIXEL_W-1:0] out_green;
    logic [PIXEL_W-1:0] out_red;
    logic               frame_end;
  } res_t;

  typedef struct packed {
    logic [1:0]                              channel_count;
    logic                                    sharpen_mode;
    logic [DIM_W-1:0]                        image_width;
    logic [DIM_W-1:0]                        image_height;
    logic [KERNEL_SIZE-1:0][COEF_ROW_W-1:0]  coef;
  } cfg_t;

  // Per-item window info: result due, which border taps are padded, last of frame.
  typedef struct packed {
    logic produce;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } pos_info_t;

endpackage

/* rtl/c3zs_pix_if.sv */
`timescale 1ns / 1ps
// Pixel request channel: valid/ready handshake with a pixel payload.
// Depends on c3zs_pkg.
interface c3zs_pix_if;
  logic               valid;
  logic               ready;
  c3zs_pkg::pix_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/c3zs_res_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with a filtered pixel payload.
// Depends on c3zs_pkg.
interface c3zs_res_if;
  logic           valid;
  logic           ready;
  c3zs_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/c3zs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module c3zs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/c3zs_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file written through the plain cfg write port.
// Depends on c3zs_pkg.
module c3zs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [c3zs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [c3zs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output c3zs_pkg::cfg_t                      cfg
);

  c3zs_pkg::cfg_t cfg_r;
  c3zs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (c3zs_pkg::cfg_index_t'(cfg_index))
        c3zs_pkg::CFG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[1:0];
        c3zs_pkg::CFG_SHARPEN_MODE:  cfg_nxt.sharpen_mode  = cfg_data[0];
        c3zs_pkg::CFG_IMAGE_WIDTH:   cfg_nxt.image_width   = cfg_data[c3zs_pkg::DIM_W-1:0];
        c3zs_pkg::CFG_IMAGE_HEIGHT:  cfg_nxt.image_height  = cfg_data[c3zs_pkg::DIM_W-1:0];
        c3zs_pkg::CFG_COEF_TOP:      cfg_nxt.coef[0]       = cfg_data;
        c3zs_pkg::CFG_COEF_MIDDLE:   cfg_nxt.coef[1]       = cfg_data;
        c3zs_pkg::CFG_COEF_BOTTOM:   cfg_nxt.coef[2]       = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= c3zs_pkg::CH_RESET;
      cfg_r.sharpen_mode  <= 1'b0;
      cfg_r.image_width   <= c3zs_pkg::WIDTH_RESET;
      cfg_r.image_height  <= c3zs_pkg::HEIGHT_RESET;
      cfg_r.coef[0]       <= '0;
      cfg_r.coef[1]       <= c3zs_pkg::COEF_MID_RESET;
      cfg_r.coef[2]       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/c3zs_raster.sv */
`timescale 1ns / 1ps
// Raster position tracker: column/row counters, line store address and
// border/output flags for each request. Depends on c3zs_pkg.
module c3zs_raster #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic [c3zs_pkg::DIM_W-1:0]        image_width,
  input  logic [c3zs_pkg::DIM_W-1:0]        image_height,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output c3zs_pkg::pos_info_t               info
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int XW = CB + 1;
  localparam int DW = c3zs_pkg::DIM_W;

  logic [CB-1:0] col_r, col_nxt, col_n;
  logic [DW-1:0] row_r, row_nxt, row_n;
  logic [XW-1:0] w_eff, col_inc;
  logic [DW-1:0] h_eff, h1;
  logic          col_zero;

  always_comb begin
    if (image_width == '0) begin
      w_eff = XW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = DW'(1);
    end else if (int'(image_height) > c3zs_pkg::HEIGHT_LIMIT) begin
      h_eff = DW'(c3zs_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
    h1 = h_eff + DW'(1);
  end

  // a column at or past the width ends the row
  always_comb begin
    if ({1'b0, col_r} >= w_eff) begin
      col_n = '0;
      row_n = row_r + DW'(1);
    end else begin
      col_n = col_r;
      row_n = row_r;
    end
    col_zero = (col_n == '0);
  end

  // result pixel sits one row and one column behind the request
  always_comb begin
    if (col_zero) begin
      info.produce = (row_n >= DW'(2)) && (row_n <= h1);
      info.top     = (row_n == DW'(2));
      info.bottom  = (row_n == h1);
      info.left    = (w_eff == XW'(1));
      info.right   = 1'b1;
      info.last    = (row_n == h1);
    end else begin
      info.produce = (row_n >= DW'(1)) && (row_n <= h_eff);
      info.top     = (row_n == DW'(1));
      info.bottom  = (row_n == h_eff);
      info.left    = (col_n == CB'(1));
      info.right   = 1'b0;
      info.last    = 1'b0;
    end
  end

  always_comb begin
    col_inc = {1'b0, col_n} + XW'(1);
    if (row_n >= h1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_n + DW'(1);
    end else begin
      col_nxt = col_inc[CB-1:0];
      row_nxt = row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign rd_addr = col_n;

endmodule

/* rtl/c3zs_kernel.sv */
`timescale 1ns / 1ps
// One channel lane: 3x3 signed Q8.8 multiply-accumulate with zero padding,
// clamp to 0..255 and optional sharpen add. Depends on c3zs_pkg.
module c3zs_kernel (
  input  logic [2:0][2:0][c3zs_pkg::PIXEL_W-1:0]                          pix,
  input  c3zs_pkg::pos_info_t                                             info,
  input  logic [c3zs_pkg::KERNEL_SIZE-1:0][c3zs_pkg::COEF_ROW_W-1:0]      coef,
  input  logic                                                            sharpen,
  input  logic                                                            enable,
  output logic [c3zs_pkg::PIXEL_W-1:0]                                    result
);

  localparam int SW = c3zs_pkg::SUM_W;
  localparam int KS = c3zs_pkg::KERNEL_SIZE;
  localparam int CW = c3zs_pkg::COEF_W;

  logic signed [SW-1:0]                  sum;
  logic signed [SW-1:0]                  shifted;
  logic signed [c3zs_pkg::PROD_W-1:0]    prod;
  logic [c3zs_pkg::PIXEL_W-1:0]          conv;
  logic [c3zs_pkg::PIXEL_W:0]            boosted;

  always_comb begin
    sum  = '0;
    prod = '0;
    for (int r = 0; r < KS; r++) begin
      for (int c = 0; c < KS; c++) begin
        if (!((r == 0 && info.top) || (r == KS - 1 && info.bottom) ||
              (c == 0 && info.left) || (c == KS - 1 && info.right))) begin
          prod = signed'(coef[r][CW*c +: CW]) * signed'({1'b0, pix[r][c]});
          sum  = sum + SW'(prod);
        end
      end
    end
  end

  always_comb begin
    shifted = sum >>> c3zs_pkg::COEF_FRACTION_BITS;
    if (sum[SW-1]) begin
      conv = '0;
    end else if (shifted > SW'(c3zs_pkg::PIXEL_MAX)) begin
      conv = c3zs_pkg::PIXEL_MAX;
    end else begin
      conv = shifted[c3zs_pkg::PIXEL_W-1:0];
    end
    boosted = {1'b0, conv} + {1'b0, pix[1][1]};
    if (!enable) begin
      result = '0;
    end else if (sharpen) begin
      result = boosted[c3zs_pkg::PIXEL_W] ? c3zs_pkg::PIXEL_MAX
                                          : boosted[c3zs_pkg::PIXEL_W-1:0];
    end else begin
      result = conv;
    end
  end

endmodule

/* rtl/conv3x3_zero_pad_clamp_sharpen.sv */
`timescale 1ns / 1ps
// 3x3 convolution with zero padding, clamping and optional sharpening.
// Top level; depends on c3zs_pkg, c3zs_pix_if, c3zs_res_if, c3zs_ram,
// c3zs_cfg, c3zs_raster and c3zs_kernel.
//
// Usage: pixels enter in raster order on in_pix, one per request; results
// leave on out_res. Set the registers through cfg_we/cfg_index/cfg_data
// while the block is idle. After the last pixel of a frame send
// image_width + 1 requests with flush set; they act as zero pixels.
// The result of pixel p leaves with request p + image_width + 1, through
// the input stage and the output register; frame_end marks the last pixel.
// Throughput is one request per cycle unless out_res stalls: line stores
// are read at accept, written at s1_go; nine taps per lane are combinational.
// Reset: positions and window cleared, registers at defaults; line store
// contents are never needed before they are written, so no clearing pass.
// Stall: a result holds in the output register; once a result-producing
// request waits in the input stage, in_pix.ready drops until out_res.ready.
module conv3x3_zero_pad_clamp_sharpen #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  c3zs_pix_if.sink                          in_pix,
  c3zs_res_if.source                        out_res,
  input  logic                              cfg_we,
  input  logic [c3zs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [c3zs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WW = c3zs_pkg::WORD_W;
  localparam int PW = c3zs_pkg::PIXEL_W;

  c3zs_pkg::cfg_t      cfg;
  c3zs_pkg::pos_info_t info;
  logic [CB-1:0]       rd_addr;

  logic acc, s1_go, out_free, grey, fwd_hit;
  logic [WW-1:0] pix_in, upper_rdata, lower_rdata, s1_top, s1_mid;

  logic                s1_valid_r;
  logic [CB-1:0]       s1_col_r;
  logic [WW-1:0]       s1_pix_r;
  c3zs_pkg::pos_info_t s1_info_r;
  logic                s1_fwd_r;
  logic [WW-1:0]       s1_fwd_top_r, s1_fwd_mid_r;

  logic [2:0][2:0][WW-1:0] win_r, win_new;
  logic [c3zs_pkg::CHANNELS-1:0][PW-1:0] lane_res;

  logic           out_valid_r;
  c3zs_pkg::res_t out_data_r;

  c3zs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  c3zs_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .image_width  (cfg.image_width),
    .image_height (cfg.image_height),
    .rd_addr      (rd_addr),
    .info         (info)
  );

  assign grey     = (cfg.channel_count == c3zs_pkg::GREY_CHANNELS);
  assign acc      = in_pix.valid && in_pix.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign s1_go    = s1_valid_r && (!s1_info_r.produce || out_free);
  assign in_pix.ready = !s1_valid_r || s1_go;

  always_comb begin
    pix_in = '0;
    if (!in_pix.payload.flush) begin
      pix_in[PW-1:0] = in_pix.payload.pixel_blue;
      if (!grey) begin
        pix_in[WW-1:PW] = {in_pix.payload.pixel_red, in_pix.payload.pixel_green};
      end
    end
  end

  // same column as the write now leaving the input stage (width of one)
  assign fwd_hit = s1_go && (rd_addr == s1_col_r);
  assign s1_top  = s1_fwd_r ? s1_fwd_top_r : upper_rdata;
  assign s1_mid  = s1_fwd_r ? s1_fwd_mid_r : lower_rdata;

  c3zs_ram #(.WIDTH(WW), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (s1_mid),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (upper_rdata)
  );

  c3zs_ram #(.WIDTH(WW), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (lower_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r     <= rd_addr;
      s1_pix_r     <= pix_in;
      s1_info_r    <= info;
      s1_fwd_r     <= fwd_hit;
      s1_fwd_top_r <= s1_mid;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  always_comb begin
    for (int r = 0; r < c3zs_pkg::KERNEL_SIZE; r++) begin
      win_new[r][0] = win_r[r][1];
      win_new[r][1] = win_r[r][2];
    end
    win_new[0][2] = s1_top;
    win_new[1][2] = s1_mid;
    win_new[2][2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go) begin
      win_r <= win_new;
    end
  end

  for (genvar ch = 0; ch < c3zs_pkg::CHANNELS; ch++) begin : g_lane
    logic [2:0][2:0][PW-1:0] lane_pix;

    always_comb begin
      for (int r = 0; r < c3zs_pkg::KERNEL_SIZE; r++) begin
        for (int c = 0; c < c3zs_pkg::KERNEL_SIZE; c++) begin
          lane_pix[r][c] = win_new[r][c][PW*ch +: PW];
        end
      end
    end

    c3zs_kernel u_kernel (
      .pix     (lane_pix),
      .info    (s1_info_r),
      .coef    (cfg.coef),
      .sharpen (cfg.sharpen_mode),
      .enable  ((ch == 0) || !grey),
      .result  (lane_res[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_info_r.produce) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_info_r.produce) begin
      out_data_r.out_blue  <= lane_res[0];
      out_data_r.out_green <= lane_res[1];
      out_data_r.out_red   <= lane_res[2];
      out_data_r.frame_end <= s1_info_r.last;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_data_r;

  a_fwd_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_go && (rd_addr == s1_col_r)) |=> s1_fwd_r)
    else $error("line store forward missed on same-column request");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_pix_r)))
    else $error("input stage changed while stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_info_r.produce) |=> out_valid_r)
    else $error("result dropped on its way to the output register");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready && s1_valid_r && s1_info_r.produce) |-> !in_pix.ready)
    else $error("request taken while both stages are full");

endmodule
